### sv/fosq_pkg.sv
package fosq_pkg;

  localparam int DEPTH        = 16;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int COUNT_BITS   = $clog2(DEPTH + 1);

  // apb register map
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam logic REG_PRIORITY_MODE = 1'b0;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // per-cell control from the top level
  typedef struct packed {
    logic push;  // accepted push that fits
    logic pop;   // accepted pop of a non-empty queue
    logic prio;  // sorted insertion
    logic occ;   // this slot holds an entry
    logic head;  // this is slot zero
  } cell_ctl_t;

endpackage

### sv/fosq_cell.sv
module fosq_cell (
  input  logic                              clk,
  input  fosq_pkg::cell_ctl_t               ctl,
  input  logic                              flag_in,
  output logic                              flag_out,
  input  logic [fosq_pkg::KEY_BITS-1:0]     new_key,
  input  logic [fosq_pkg::PAYLOAD_BITS-1:0] new_payload,
  input  logic [fosq_pkg::KEY_BITS-1:0]     left_key,
  input  logic [fosq_pkg::PAYLOAD_BITS-1:0] left_payload,
  input  logic [fosq_pkg::KEY_BITS-1:0]     right_key,
  input  logic [fosq_pkg::PAYLOAD_BITS-1:0] right_payload,
  output logic [fosq_pkg::KEY_BITS-1:0]     key,
  output logic [fosq_pkg::PAYLOAD_BITS-1:0] payload,
  output logic [fosq_pkg::KEY_BITS-1:0]     key_next,
  output logic [fosq_pkg::PAYLOAD_BITS-1:0] payload_next
);

  logic here;

  // insertion point is at or before this slot
  always_comb begin
    if (!ctl.occ) begin
      here = 1'b1;
    end else if (!ctl.prio) begin
      here = 1'b0;
    end else if (ctl.head) begin
      here = (new_key < key);
    end else begin
      here = (key >= new_key);
    end
    flag_out = flag_in | here;
  end

  always_comb begin
    key_next     = key;
    payload_next = payload;
    if (ctl.pop) begin
      key_next     = right_key;
      payload_next = right_payload;
    end else if (ctl.push) begin
      if (flag_in) begin
        key_next     = left_key;
        payload_next = left_payload;
      end else if (flag_out) begin
        key_next     = new_key;
        payload_next = new_payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    key     <= key_next;
    payload <= payload_next;
  end

endmodule

### sv/fifo_or_sorted_priority_queue.sv
// Bounded queue of up to DEPTH keyed entries, kept in a row of shift cells with
// the head in cell zero. With priority_mode at 0 a push appends at the tail;
// at 1 the new entry goes before the first entry whose key is not smaller,
// except that a key equal to the head's goes behind the head. A pop removes
// the head. Every transaction returns one result: the head after the
// operation (zero when empty), the count, and empty, overflow and underflow
// flags. A push to a full queue and a pop of an empty one leave the state
// alone. One transaction is taken every cycle while in_stall is low; the
// result is registered in the cycle after acceptance. The per-cycle limit
// is the ripple of the insertion flag through all cells. Changing the mode
// does not reorder entries already stored.
module fifo_or_sorted_priority_queue (
  input  logic                                clk,
  input  logic                                rst,
  // apb configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fosq_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [fosq_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [fosq_pkg::PDATA_BITS-1:0]     prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [fosq_pkg::KEY_BITS-1:0]       entry_key,
  input  logic [fosq_pkg::PAYLOAD_BITS-1:0]   entry_payload,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fosq_pkg::KEY_BITS-1:0]       head_key,
  output logic [fosq_pkg::PAYLOAD_BITS-1:0]   head_payload,
  output logic [fosq_pkg::COUNT_BITS-1:0]     entry_count,
  output logic                                is_empty,
  output logic                                overflow,
  output logic                                underflow
);

  localparam int D  = fosq_pkg::DEPTH;
  localparam int KB = fosq_pkg::KEY_BITS;
  localparam int PB = fosq_pkg::PAYLOAD_BITS;
  localparam int CB = fosq_pkg::COUNT_BITS;

  logic          priority_mode;
  logic [CB-1:0] count;
  logic [CB-1:0] count_next;

  // ---------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------
  logic reg_sel;
  assign reg_sel = (paddr[2] == fosq_pkg::REG_PRIORITY_MODE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      priority_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[0] = priority_mode;
    end
  end

  // ---------------------------------------------------------------
  // transaction accept and operation decode
  // ---------------------------------------------------------------
  logic accept;
  logic is_full;
  logic is_zero;
  logic do_push;
  logic do_pop;
  logic over;
  logic under;

  // output register frees up when its result is taken in the same cycle
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign is_full = (count == CB'(D));
  assign is_zero = (count == '0);
  assign do_push = accept && (operation == fosq_pkg::OP_PUSH) && !is_full;
  assign do_pop  = accept && (operation == fosq_pkg::OP_POP) && !is_zero;
  assign over    = (operation == fosq_pkg::OP_PUSH) && is_full;
  assign under   = (operation == fosq_pkg::OP_POP) && is_zero;

  always_comb begin
    count_next = count;
    if (do_push) begin
      count_next = count + CB'(1);
    end else if (do_pop) begin
      count_next = count - CB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // ---------------------------------------------------------------
  // cell chain: flag ripples from head to tail, data shifts one slot
  // ---------------------------------------------------------------
  logic [KB-1:0] cell_key      [D];
  logic [PB-1:0] cell_payload  [D];
  logic [KB-1:0] cell_key_nx   [D];
  logic [PB-1:0] cell_payload_nx [D];
  logic [D:0]    flag;

  assign flag[0] = 1'b0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    fosq_pkg::cell_ctl_t ctl;
    logic [KB-1:0]       lk;
    logic [PB-1:0]       lp;
    logic [KB-1:0]       rk;
    logic [PB-1:0]       rp;

    assign ctl.push = do_push;
    assign ctl.pop  = do_pop;
    assign ctl.prio = priority_mode;
    assign ctl.occ  = (CB'(i) < count);
    assign ctl.head = (i == 0);

    if (i == 0) begin : g_first
      assign lk = '0;
      assign lp = '0;
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign lp = cell_payload[i-1];
    end

    if (i == D - 1) begin : g_last
      assign rk = '0;
      assign rp = '0;
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rp = cell_payload[i+1];
    end

    fosq_cell u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .flag_in       (flag[i]),
      .flag_out      (flag[i+1]),
      .new_key       (entry_key),
      .new_payload   (entry_payload),
      .left_key      (lk),
      .left_payload  (lp),
      .right_key     (rk),
      .right_payload (rp),
      .key           (cell_key[i]),
      .payload       (cell_payload[i]),
      .key_next      (cell_key_nx[i]),
      .payload_next  (cell_payload_nx[i])
    );
  end

  // ---------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (count_next == '0) begin
        head_key     <= '0;
        head_payload <= '0;
      end else begin
        head_key     <= cell_key_nx[0];
        head_payload <= cell_payload_nx[0];
      end
      entry_count <= count_next;
      is_empty    <= (count_next == '0);
      overflow    <= over;
      underflow   <= under;
    end
  end

endmodule

### tb/sv/tb_fifo_or_sorted_priority_queue.sv
module tb_fifo_or_sorted_priority_queue;
  import fosq_pkg::*;

  // watchdog, far above the slowest legal run (every transaction paying the
  // longest sender gap plus the longest receiver stall, plus the drains)
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int MAX_IDLE     = 13;
  localparam logic [PADDR_BITS-1:0] MODE_ADDR = PADDR_BITS'(4 * REG_PRIORITY_MODE);

  // one result transaction as the block reports it
  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [COUNT_BITS-1:0]   count;
    logic                    empty;
    logic                    over;
    logic                    under;
  } head_report_t;

  // shadow copy of the queue; every accepted transaction yields the head report
  // it must produce, and every result is checked against the oldest one
  class queue_tracker;
    logic [KEY_BITS-1:0]     keys [DEPTH];
    logic [PAYLOAD_BITS-1:0] pays [DEPTH];
    int                      count;
    bit                      sorted;
    head_report_t            expected_heads [$];
    int                      errors;

    function new();
      count  = 0;
      sorted = 1'b0;
      errors = 0;
    endfunction

    function void set_mode(bit m);
      sorted = m;
    endfunction

    function int pending();
      return expected_heads.size();
    endfunction

    function void note_op(op_t op, logic [KEY_BITS-1:0] key, logic [PAYLOAD_BITS-1:0] pay);
      head_report_t r;
      int           pos;
      r = '0;
      if (op == OP_PUSH) begin
        if (count >= DEPTH) begin
          r.over = 1'b1;
        end else begin
          pos = count;
          if (sorted) begin
            // smaller than the head: new head; otherwise first slot behind
            // the head whose key is not smaller, so a tie with the head lands
            // right behind it
            if (count == 0 || key < keys[0]) begin
              pos = 0;
            end else begin
              for (int i = count - 1; i >= 1; i--)
                if (keys[i] >= key) pos = i;
            end
          end
          for (int i = count; i > pos; i--) begin
            keys[i] = keys[i-1];
            pays[i] = pays[i-1];
          end
          keys[pos] = key;
          pays[pos] = pay;
          count++;
        end
      end else begin
        if (count == 0) begin
          r.under = 1'b1;
        end else begin
          for (int i = 0; i < count - 1; i++) begin
            keys[i] = keys[i+1];
            pays[i] = pays[i+1];
          end
          count--;
        end
      end
      if (count > 0) begin
        r.key     = keys[0];
        r.payload = pays[0];
      end
      r.count = COUNT_BITS'(count);
      r.empty = (count == 0);
      expected_heads.push_back(r);
    endfunction

    function void check_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_head(head_report_t got);
      head_report_t want;
      if (expected_heads.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = expected_heads.pop_front();
        check_field("head_key", want.key, got.key);
        check_field("head_payload", want.payload, got.payload);
        check_field("entry_count", want.count, got.count);
        check_field("is_empty", want.empty, got.empty);
        check_field("overflow", want.over, got.over);
        check_field("underflow", want.under, got.under);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_BITS-1:0]   paddr;
  logic [PDATA_BITS-1:0]   pwdata;
  logic [PDATA_BITS-1:0]   prdata;
  logic                    pready;
  logic                    in_valid;
  logic                    in_stall;
  logic                    operation;
  logic [KEY_BITS-1:0]     entry_key;
  logic [PAYLOAD_BITS-1:0] entry_payload;
  logic                    out_valid;
  logic                    out_stall;
  logic [KEY_BITS-1:0]     head_key;
  logic [PAYLOAD_BITS-1:0] head_payload;
  logic [COUNT_BITS-1:0]   entry_count;
  logic                    is_empty;
  logic                    overflow;
  logic                    underflow;

  queue_tracker sb;
  int           items_sent;
  int           cycle_count;
  bit           tx_calm;  // sender gaps forced to zero
  bit           rx_calm;  // receiver never stalls

  fifo_or_sorted_priority_queue u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .entry_key     (entry_key),
    .entry_payload (entry_payload),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .head_key      (head_key),
    .head_payload  (head_payload),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .overflow      (overflow),
    .underflow     (underflow)
  );

  always #2 clk = ~clk;

  // sampling at the rising edge sees the values from before the block's own
  // updates; results are checked before the new transaction is noted since
  // the block answers in the cycle after acceptance at the earliest
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_head({head_key, head_payload, entry_count, is_empty, overflow, underflow});
      if (in_valid && !in_stall)
        sb.note_op(op_t'(operation), entry_key, entry_payload);
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // receiver: a fresh stall length for every result transaction
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // called and returning at a falling edge; valid stays high when the next
  // transaction follows with no gap, so it is never dropped and raised at once
  task automatic send_item(op_t op, logic [KEY_BITS-1:0] key, logic [PAYLOAD_BITS-1:0] pay);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    entry_key     <= key;
    entry_payload <= pay;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // hold off until every expected result has come back, then keep the input
  // idle so the output register has nothing in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // one apb transfer: setup phase, then access until pready, then psel and
  // penable drop before returning so a following transfer starts at a later falling edge
  task automatic apb_transfer(bit wr, logic [PDATA_BITS-1:0] wdata,
                              output logic [PDATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MODE_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // only while idle; upper data bits are junk the register must ignore
  task automatic write_mode(bit m);
    logic [PDATA_BITS-1:0] wdata;
    logic [PDATA_BITS-1:0] rdata;
    wdata    = $urandom;
    wdata[0] = m;
    apb_transfer(1'b1, wdata, rdata);
    sb.set_mode(m);
    apb_transfer(1'b0, '0, rdata);
    sb.check_field("priority_mode readback", m, rdata[0]);
  endtask

  // small keys give lots of ties, including ties with the head
  function automatic logic [KEY_BITS-1:0] draw_key();
    case ($urandom_range(0, 3))
      0, 1:    return KEY_BITS'($urandom_range(0, 7));
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [PAYLOAD_BITS-1:0] draw_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PAYLOAD_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int push_pct;
    int phase_len;
    clk           = 1'b0;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    operation     = OP_PUSH;
    entry_key     = '0;
    entry_payload = '0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    items_sent    = 0;
    sb            = new();

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fifo order from reset: underflow on empty, extreme keys and payloads
    send_item(OP_POP,  '0, '0);
    send_item(OP_PUSH, '1, '1);
    send_item(OP_PUSH, '0, '0);
    send_item(OP_POP,  '0, '0);
    send_item(OP_POP,  '0, '0);
    send_item(OP_POP,  '0, '0);
    drain();

    // sorted insertion: smaller key takes the head, ties with the head go
    // behind it, largest key goes to the tail
    write_mode(1'b1);
    send_item(OP_PUSH, 16'd100,  32'h0000_0a0a);
    send_item(OP_PUSH, 16'd50,   32'h0000_0b0b);
    send_item(OP_PUSH, 16'd50,   32'h0000_0c0c);
    send_item(OP_PUSH, 16'd50,   32'h0000_0d0d);
    send_item(OP_PUSH, 16'd0,    32'h0000_0e0e);
    send_item(OP_PUSH, 16'hffff, 32'hffff_0000);
    send_item(OP_PUSH, 16'd0,    32'h0000_0f0f);
    send_item(OP_POP,  '0, '0);
    send_item(OP_POP,  '0, '0);
    send_item(OP_POP,  '0, '0);
    drain();

    // back to fifo with entries still stored: no reordering, append at tail
    write_mode(1'b0);
    send_item(OP_PUSH, 16'd1, 32'h1234_5678);
    send_item(OP_POP,  '0, '0);
    send_item(OP_POP,  '0, '0);
    drain();

    // random phases: each has its own push bias so the queue swings between
    // full (overflow) and empty (underflow); mode changes land on a queue that
    // usually still holds entries
    while (items_sent < RANDOM_ITEMS + 20) begin
      drain();
      write_mode($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0:       push_pct = 25;
        1:       push_pct = 50;
        2:       push_pct = 75;
        default: push_pct = 92;
      endcase
      phase_len = $urandom_range(30, 120);
      tx_calm   = ($urandom_range(0, 3) == 0);
      rx_calm   = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < push_pct)
          send_item(OP_PUSH, draw_key(), draw_payload());
        else
          send_item(OP_POP, draw_key(), draw_payload());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### files.f
sv/fosq_pkg.sv
sv/fosq_cell.sv
sv/fifo_or_sorted_priority_queue.sv
tb/sv/tb_fifo_or_sorted_priority_queue.sv
